// ----- rtl/core/tbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants for the barycentric weight pipeline
// fixed-point widths of every datapath stage and the divider geometry
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int CW        = 32;            // input coordinate width, Q16.16
  localparam int EW        = CW + 1;        // edge / offset component, Q17.16
  localparam int PW        = 2 * EW;        // component product
  localparam int DW        = 68;            // dot product, Q36.32
  localparam int HW        = DW / 2;        // half of a dot product for the split multiply
  localparam int PPW       = 2 * HW + 1;    // signed x unsigned-half partial product
  localparam int MW        = 2 * DW;        // full dot x dot product
  localparam int NW        = 139;           // determinant and numerators, Q75.64
  localparam int DENW      = NW - 1;        // positive determinant magnitude
  localparam int RW        = DENW;          // divider partial remainder
  localparam int QW        = 32;            // weight width, Q8.24
  localparam int QFRAC     = 24;
  localparam int LOWB      = QW - QFRAC;    // numerator bits fed into the divider steps
  localparam int DIV_STEPS = QW;
  localparam int DIV_LAT   = DIV_STEPS + 3; // magnitude, range check, steps, result
  localparam int GRAM_LAT  = 3;
  localparam int WMUL_LAT  = 2;
  localparam int PIPE_LAT  = GRAM_LAT + WMUL_LAT + 2 + DIV_LAT;

  localparam logic [QW-1:0] QMAX     = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QMIN_MAG = {1'b1, {(QW-1){1'b0}}};

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t vec3_t [3];
  typedef logic signed [DW-1:0] dot_t;
  typedef logic signed [MW-1:0] wprod_t;
  typedef logic signed [NW-1:0] wide_t;
  typedef logic signed [QW-1:0] weight_t;

endpackage
`default_nettype wire

// ----- rtl/core/tbc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_if: item channels of the barycentric weight block
// valid/ready handshake, payload carried alongside
// ----------------------------------------------------------------------------
interface tbc_in_if;
  import tbc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  coord_t vert_a_x;
  coord_t vert_a_y;
  coord_t vert_a_z;
  coord_t vert_b_x;
  coord_t vert_b_y;
  coord_t vert_b_z;
  coord_t vert_c_x;
  coord_t vert_c_y;
  coord_t vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

interface tbc_out_if;
  import tbc_pkg::*;

  logic    valid;
  logic    ready;
  weight_t weight_u;
  weight_t weight_v;
  weight_t weight_w;
  logic    degenerate;
  logic    saturated;

  modport source (
    output valid, weight_u, weight_v, weight_w, degenerate, saturated,
    input  ready
  );
  modport sink (
    input  valid, weight_u, weight_v, weight_w, degenerate, saturated,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/core/triangle_barycentric_coords_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_barycentric_coords_top: barycentric weights of a point in a triangle
// streaming pipeline that takes, unless the receiver stalls, one item per cycle
// ----------------------------------------------------------------------------
// usage
//   in_item carries the query point and the three triangle vertices, signed
//   Q16.16; an item is taken at a clock edge with valid and ready both high
//   out_item returns weights u, v, w in signed Q8.24 with the degenerate and
//   saturated flags, one result item for each input item, in order
//   a new item may be taken every cycle unless the receiver stalls, so
//   sustained throughput is one item per clock
//   the pipeline is the dot product, wide multiply and numerator stages
//   followed by the weight dividers with their 32 one-bit quotient stages
//   when the receiver stalls with a result waiting, the whole pipeline holds;
//   in_item.ready drops only while the output register is full and not taken
//   synchronous active-low reset clears every valid bit; no result is shown
//   until the first accepted item has come through
// ----------------------------------------------------------------------------
module triangle_barycentric_coords_top (
  input  logic      clk,
  input  logic      rst_n,
  tbc_in_if.sink    in_item,
  tbc_out_if.source out_item
);
  import tbc_pkg::*;

  // pipeline advance: everything moves unless a finished item is stuck at the end
  logic                en;
  logic [PIPE_LAT-1:0] valid_r;
  logic [PIPE_LAT-1:0] valid_nxt;

  vec3_t pnt, va, vb, vc;
  dot_t  d00, d01, d11, d20, d21;

  // wide products: den = d00*d11 - d01*d01, nv = d11*d20 - d01*d21,
  // nw = d00*d21 - d01*d20
  wprod_t m_den_a, m_den_b, m_nv_a, m_nv_b, m_nw_a, m_nw_b;

  wide_t den6_r, nv6_r, nw6_r;
  wide_t den7_r, nu7_r, nv7_r, nw7_r;
  logic  deg7_r;
  logic [DIV_LAT-1:0] deg_r;

  weight_t wu, wv, ww;
  logic    su, sv, sw;
  logic    deg_out;

  assign en        = !valid_r[PIPE_LAT-1] || out_item.ready;
  assign in_item.ready = en;
  assign valid_nxt = {valid_r[PIPE_LAT-2:0], in_item.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  assign pnt = '{in_item.point_x, in_item.point_y, in_item.point_z};
  assign va  = '{in_item.vert_a_x, in_item.vert_a_y, in_item.vert_a_z};
  assign vb  = '{in_item.vert_b_x, in_item.vert_b_y, in_item.vert_b_z};
  assign vc  = '{in_item.vert_c_x, in_item.vert_c_y, in_item.vert_c_z};

  // edges and dot products, three stages
  tbc_gram u_gram (
    .clk (clk), .en (en),
    .pnt (pnt), .va (va), .vb (vb), .vc (vc),
    .d00 (d00), .d01 (d01), .d11 (d11), .d20 (d20), .d21 (d21)
  );

  // six wide multiplies, two stages each
  tbc_wmul u_mul_den_a (.clk (clk), .en (en), .a (d00), .b (d11), .p (m_den_a));
  tbc_wmul u_mul_den_b (.clk (clk), .en (en), .a (d01), .b (d01), .p (m_den_b));
  tbc_wmul u_mul_nv_a  (.clk (clk), .en (en), .a (d11), .b (d20), .p (m_nv_a));
  tbc_wmul u_mul_nv_b  (.clk (clk), .en (en), .a (d01), .b (d21), .p (m_nv_b));
  tbc_wmul u_mul_nw_a  (.clk (clk), .en (en), .a (d00), .b (d21), .p (m_nw_a));
  tbc_wmul u_mul_nw_b  (.clk (clk), .en (en), .a (d01), .b (d20), .p (m_nw_b));

  always_ff @(posedge clk) begin
    if (en) begin
      // determinant and the v, w numerators
      den6_r <= NW'(m_den_a) - NW'(m_den_b);
      nv6_r  <= NW'(m_nv_a) - NW'(m_nv_b);
      nw6_r  <= NW'(m_nw_a) - NW'(m_nw_b);

      // u numerator: the constant one enters as the determinant itself
      den7_r <= den6_r;
      nu7_r  <= den6_r - nv6_r - nw6_r;
      nv7_r  <= nv6_r;
      nw7_r  <= nw6_r;
      deg7_r <= den6_r[NW-1] || (den6_r == '0);

      // degenerate flag rides alongside the dividers
      deg_r  <= {deg_r[DIV_LAT-2:0], deg7_r};
    end
  end

  // three dividers, one per weight
  tbc_div u_div_u (
    .clk (clk), .en (en), .num (nu7_r), .den (den7_r[DENW-1:0]),
    .weight (wu), .sat (su)
  );
  tbc_div u_div_v (
    .clk (clk), .en (en), .num (nv7_r), .den (den7_r[DENW-1:0]),
    .weight (wv), .sat (sv)
  );
  tbc_div u_div_w (
    .clk (clk), .en (en), .num (nw7_r), .den (den7_r[DENW-1:0]),
    .weight (ww), .sat (sw)
  );

  // degenerate triangle forces zero weights and no saturation
  assign deg_out             = deg_r[DIV_LAT-1];
  assign out_item.valid      = valid_r[PIPE_LAT-1];
  assign out_item.weight_u   = deg_out ? '0 : wu;
  assign out_item.weight_v   = deg_out ? '0 : wv;
  assign out_item.weight_w   = deg_out ? '0 : ww;
  assign out_item.degenerate = deg_out;
  assign out_item.saturated  = !deg_out && (su || sv || sw);

endmodule
`default_nettype wire

// ----- rtl/core/tbc_gram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_gram: edge vectors and the five dot products
// three stages: differences, component products, sums
// ----------------------------------------------------------------------------
module tbc_gram (
  input  logic          clk,
  input  logic          en,
  input  tbc_pkg::vec3_t pnt,
  input  tbc_pkg::vec3_t va,
  input  tbc_pkg::vec3_t vb,
  input  tbc_pkg::vec3_t vc,
  output tbc_pkg::dot_t d00,
  output tbc_pkg::dot_t d01,
  output tbc_pkg::dot_t d11,
  output tbc_pkg::dot_t d20,
  output tbc_pkg::dot_t d21
);
  import tbc_pkg::*;

  logic signed [EW-1:0] e0_r [3], e1_r [3], e2_r [3];
  logic signed [EW-1:0] e0_nxt [3], e1_nxt [3], e2_nxt [3];
  logic signed [PW-1:0] p00_r [3], p01_r [3], p11_r [3], p20_r [3], p21_r [3];
  logic signed [PW-1:0] p00_nxt [3], p01_nxt [3], p11_nxt [3], p20_nxt [3], p21_nxt [3];
  dot_t d00_r, d01_r, d11_r, d20_r, d21_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0_nxt[k]  = EW'(vb[k]) - EW'(va[k]);
      e1_nxt[k]  = EW'(vc[k]) - EW'(va[k]);
      e2_nxt[k]  = EW'(pnt[k]) - EW'(va[k]);
      p00_nxt[k] = PW'(e0_r[k]) * PW'(e0_r[k]);
      p01_nxt[k] = PW'(e0_r[k]) * PW'(e1_r[k]);
      p11_nxt[k] = PW'(e1_r[k]) * PW'(e1_r[k]);
      p20_nxt[k] = PW'(e2_r[k]) * PW'(e0_r[k]);
      p21_nxt[k] = PW'(e2_r[k]) * PW'(e1_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e0_r[k]  <= e0_nxt[k];
        e1_r[k]  <= e1_nxt[k];
        e2_r[k]  <= e2_nxt[k];
        p00_r[k] <= p00_nxt[k];
        p01_r[k] <= p01_nxt[k];
        p11_r[k] <= p11_nxt[k];
        p20_r[k] <= p20_nxt[k];
        p21_r[k] <= p21_nxt[k];
      end
      d00_r <= DW'(p00_r[0]) + DW'(p00_r[1]) + DW'(p00_r[2]);
      d01_r <= DW'(p01_r[0]) + DW'(p01_r[1]) + DW'(p01_r[2]);
      d11_r <= DW'(p11_r[0]) + DW'(p11_r[1]) + DW'(p11_r[2]);
      d20_r <= DW'(p20_r[0]) + DW'(p20_r[1]) + DW'(p20_r[2]);
      d21_r <= DW'(p21_r[0]) + DW'(p21_r[1]) + DW'(p21_r[2]);
    end
  end

  assign d00 = d00_r;
  assign d01 = d01_r;
  assign d11 = d11_r;
  assign d20 = d20_r;
  assign d21 = d21_r;

endmodule
`default_nettype wire

// ----- rtl/core/tbc_wmul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_wmul: signed dot x dot multiplier
// halves multiplied in one stage, partial products summed in the next
// ----------------------------------------------------------------------------
module tbc_wmul (
  input  logic            clk,
  input  logic            en,
  input  tbc_pkg::dot_t   a,
  input  tbc_pkg::dot_t   b,
  output tbc_pkg::wprod_t p
);
  import tbc_pkg::*;

  logic signed [HW-1:0]  ah, bh;
  logic signed [HW:0]    al_x, bl_x;
  logic signed [DW-1:0]  phh_r;
  logic signed [PPW-1:0] phl_r, plh_r;
  logic [DW-1:0]         pll_r;
  wprod_t                p_r;

  // upper halves signed, lower halves unsigned
  assign ah   = a[DW-1:HW];
  assign bh   = b[DW-1:HW];
  assign al_x = {1'b0, a[HW-1:0]};
  assign bl_x = {1'b0, b[HW-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      phh_r <= DW'(ah) * DW'(bh);
      phl_r <= PPW'(ah) * PPW'(bl_x);
      plh_r <= PPW'(al_x) * PPW'(bh);
      pll_r <= DW'(a[HW-1:0]) * DW'(b[HW-1:0]);
      p_r   <= (MW'(phh_r) << (2 * HW)) + (MW'(phl_r) << HW)
             + (MW'(plh_r) << HW) + MW'(pll_r);
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- rtl/core/tbc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_div: pipelined fixed-point divider, one quotient bit per stage
// weight = num * 2^24 / den truncated toward zero, saturated to 32 bits
// ----------------------------------------------------------------------------
module tbc_div (
  input  logic               clk,
  input  logic               en,
  input  tbc_pkg::wide_t     num,
  input  logic [tbc_pkg::DENW-1:0] den,
  output tbc_pkg::weight_t   weight,
  output logic               sat
);
  import tbc_pkg::*;

  // magnitude stage
  logic [NW-1:0]   mag_r;
  logic            neg_a_r;
  logic [DENW-1:0] den_a_r;

  // step stages, index 0 is the range check stage
  logic [RW-1:0]   rem_r   [DIV_STEPS+1];
  logic [QW-1:0]   q_r     [DIV_STEPS+1];
  logic [LOWB-1:0] lb_r    [DIV_STEPS+1];
  logic [DENW-1:0] den_r   [DIV_STEPS+1];
  logic            neg_r   [DIV_STEPS+1];
  logic            ovf_r   [DIV_STEPS+1];

  logic [RW-1:0]   rem_nxt [DIV_STEPS];
  logic [QW-1:0]   q_nxt   [DIV_STEPS];
  logic [RW:0]     trial   [DIV_STEPS];

  weight_t         weight_r;
  logic            sat_r;
  logic [QW-1:0]   limit;
  logic [QW-1:0]   qf;
  logic            sat_nxt;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_r[k], lb_r[k][LOWB-1]};
      if (trial[k] >= (RW+1)'(den_r[k])) begin
        rem_nxt[k] = RW'(trial[k] - (RW+1)'(den_r[k]));
        q_nxt[k]   = {q_r[k][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = RW'(trial[k]);
        q_nxt[k]   = {q_r[k][QW-2:0], 1'b0};
      end
    end
  end

  assign qf      = q_r[DIV_STEPS];
  assign limit   = neg_r[DIV_STEPS] ? QMIN_MAG : QMAX;
  assign sat_nxt = ovf_r[DIV_STEPS] || (qf > limit);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r <= num[NW-1];
      mag_r   <= num[NW-1] ? NW'(-num) : NW'(num);
      den_a_r <= den;

      // quotient needs more than 32 bits when mag >= den * 2^8
      ovf_r[0] <= (NW + LOWB)'(mag_r) >= {den_a_r, {(LOWB + 1){1'b0}}} >> 1;
      rem_r[0] <= RW'(mag_r >> LOWB);
      lb_r[0]  <= mag_r[LOWB-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den_a_r;
      neg_r[0] <= neg_a_r;

      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        q_r[k+1]   <= q_nxt[k];
        lb_r[k+1]  <= {lb_r[k][LOWB-2:0], 1'b0};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end

      sat_r    <= sat_nxt;
      weight_r <= sat_nxt ? limit : (neg_r[DIV_STEPS] ? QW'(0) - qf : qf);
    end
  end

  assign weight = weight_r;
  assign sat    = sat_r;

endmodule
`default_nettype wire

// ----- tb/triangle_barycentric_coords_top_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_barycentric_coords_top_test: self-checking bench for the weight pipeline
// drives point/triangle items with random gaps, predicts u, v, w and flags
// with exact wide integer math, and compares every result item in order
// ----------------------------------------------------------------------------
module triangle_barycentric_coords_top_test;
  import tbc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_OFF_CYCLES = 120;

  // one input item and one result item
  typedef struct {
    coord_t c [12];
  } tri_item_t;

  typedef struct {
    weight_t u;
    weight_t v;
    weight_t w;
    logic    degen;
    logic    sat;
  } weights_t;

  logic clk;
  logic rst_n;

  tbc_in_if  in_item ();
  tbc_out_if out_item ();

  triangle_barycentric_coords_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  weights_t expected_weights [$];
  int       error_count;
  int       idle_cycles;
  bit       hold_off;        // receiver long stall request
  bit       timed_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: exact integer math, then truncating division with saturation
  // ---------------------------------------------------------------------------
  function automatic logic signed [191:0] sx(input coord_t v);
    sx = {{160{v[31]}}, v};
  endfunction

  // num * 2^24 / den toward zero, clipped to 32 bits; den > 0
  function automatic weight_t scaled_quotient(input logic signed [191:0] num,
                                              input logic signed [191:0] den,
                                              inout logic sat);
    logic [191:0] mag;
    logic [191:0] q;
    mag = num[191] ? -num : num;
    q   = (mag << QFRAC) / den;
    if (num[191]) begin
      if (q > 192'h80000000) begin
        sat = 1'b1;
        return 32'h80000000;
      end
      return -q[31:0];
    end
    if (q > 192'h7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    return q[31:0];
  endfunction

  function automatic weights_t predict_weights(input tri_item_t it);
    logic signed [191:0] e0 [3];
    logic signed [191:0] e1 [3];
    logic signed [191:0] e2 [3];
    logic signed [191:0] d00, d01, d11, d20, d21, den, nv, nw, nu;
    weights_t r;
    logic sat;
    for (int k = 0; k < 3; k++) begin
      e0[k] = sx(it.c[6+k]) - sx(it.c[3+k]);
      e1[k] = sx(it.c[9+k]) - sx(it.c[3+k]);
      e2[k] = sx(it.c[k])   - sx(it.c[3+k]);
    end
    d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
    d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
    den = d00*d11 - d01*d01;
    sat = 1'b0;
    if (den <= 0) begin
      r = '{u: '0, v: '0, w: '0, degen: 1'b1, sat: 1'b0};
      return r;
    end
    nv = d11*d20 - d01*d21;
    nw = d00*d21 - d01*d20;
    nu = den - nv - nw;
    r.u   = scaled_quotient(nu, den, sat);
    r.v   = scaled_quotient(nv, den, sat);
    r.w   = scaled_quotient(nw, den, sat);
    r.degen = 1'b0;
    r.sat   = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one item, random gap first, waits for the handshake
  // valid stays high into the next item when there is no gap
  // ---------------------------------------------------------------------------
  task automatic send_item(input tri_item_t it, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      in_item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.valid    <= 1'b1;
    in_item.point_x  <= it.c[0];
    in_item.point_y  <= it.c[1];
    in_item.point_z  <= it.c[2];
    in_item.vert_a_x <= it.c[3];
    in_item.vert_a_y <= it.c[4];
    in_item.vert_a_z <= it.c[5];
    in_item.vert_b_x <= it.c[6];
    in_item.vert_b_y <= it.c[7];
    in_item.vert_b_z <= it.c[8];
    in_item.vert_c_x <= it.c[9];
    in_item.vert_c_y <= it.c[10];
    in_item.vert_c_z <= it.c[11];
    do @(posedge clk); while (!in_item.ready);
    expected_weights.insert(expected_weights.size(), predict_weights(it));
    @(negedge clk);
  endtask

  // coordinate generators
  function automatic coord_t any_coord();
    case ($urandom_range(5, 0))
      0:       return 32'h80000000;
      1:       return 32'h7FFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // moderate triangle near origin so weights mostly stay in range
  function automatic tri_item_t sane_triangle(input int span);
    tri_item_t it;
    for (int i = 0; i < 12; i++)
      it.c[i] = $signed($urandom_range(2 * span, 0)) - span;
    return it;
  endfunction

  function automatic tri_item_t make_item(input coord_t p [3], input coord_t a [3],
                                          input coord_t b [3], input coord_t c [3]);
    tri_item_t it;
    for (int k = 0; k < 3; k++) begin
      it.c[k] = p[k]; it.c[3+k] = a[k]; it.c[6+k] = b[k]; it.c[9+k] = c[k];
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random wait per item, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_item.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(4, 0);
      if (hold_off) begin
        stall    = HOLD_OFF_CYCLES;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        out_item.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_item.ready <= 1'b1;
      do @(posedge clk); while (!out_item.valid);
      @(negedge clk);
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    weights_t exp_w;
    if (rst_n && out_item.valid && out_item.ready) begin
      if (expected_weights.size() == 0) begin
        $error("result item with nothing expected");
        error_count++;
      end else begin
        exp_w = expected_weights.pop_front();
        if (out_item.weight_u !== exp_w.u) begin
          $error("weight_u expected %h actual %h", exp_w.u, out_item.weight_u);
          error_count++;
        end
        if (out_item.weight_v !== exp_w.v) begin
          $error("weight_v expected %h actual %h", exp_w.v, out_item.weight_v);
          error_count++;
        end
        if (out_item.weight_w !== exp_w.w) begin
          $error("weight_w expected %h actual %h", exp_w.w, out_item.weight_w);
          error_count++;
        end
        if (out_item.degenerate !== exp_w.degen) begin
          $error("degenerate expected %b actual %b", exp_w.degen, out_item.degenerate);
          error_count++;
        end
        if (out_item.saturated !== exp_w.sat) begin
          $error("saturated expected %b actual %b", exp_w.sat, out_item.saturated);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted item
  always @(posedge clk) begin
    if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("triangle_barycentric_coords_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // unit right triangle, points inside, on vertices and outside
  task automatic test_basic_triangle();
    coord_t o [3] = '{0, 0, 0};
    coord_t x [3] = '{32'h00010000, 0, 0};
    coord_t y [3] = '{0, 32'h00010000, 0};
    coord_t p [3] = '{32'h00004000, 32'h00004000, 32'h00001000};
    coord_t q [3] = '{32'hFFFD0000, 32'h00050000, 32'h7FFFFFFF};
    send_item(make_item(p, o, x, y));
    send_item(make_item(o, o, x, y));
    send_item(make_item(x, o, x, y));
    send_item(make_item(y, o, x, y));
    send_item(make_item(q, o, x, y));
  endtask

  // degenerate: all same point, collinear, min/max extremes
  task automatic test_degenerate();
    coord_t mn [3] = '{32'h80000000, 32'h80000000, 32'h80000000};
    coord_t mx [3] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    coord_t md [3] = '{32'hC0000000, 32'hC0000000, 32'hC0000000};
    send_item(make_item(mx, mn, mn, mn));
    send_item(make_item(mn, mn, mx, md));
    send_item(make_item(mx, mx, mx, mx));
    send_item(make_item(md, mn, md, mx));
  endtask

  // tiny triangle, far points: weights clip both ways; last, a wide triangle queried at a vertex
  task automatic test_saturation();
    coord_t a [3] = '{0, 0, 0};
    coord_t b [3] = '{1, 0, 0};
    coord_t c [3] = '{0, 1, 0};
    coord_t p [3] = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
    coord_t r [3] = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    coord_t s [3] = '{32'h00000100, 0, 0};
    send_item(make_item(p, a, b, c));
    send_item(make_item(r, a, b, c));
    send_item(make_item(s, a, b, c));
    send_item(make_item(p, p, r, c));
  endtask

  // widest spans on every vertex
  task automatic test_extremes();
    coord_t mn [3] = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    coord_t mx [3] = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000};
    coord_t c  [3] = '{32'h80000000, 32'h80000000, 32'h7FFFFFFF};
    coord_t p  [3] = '{32'hFFFFFFFF, 0, 32'h00000001};
    send_item(make_item(p, mn, mx, c));
    send_item(make_item(mx, mn, mx, c));
    send_item(make_item(c, c, mn, mx));
  endtask

  // mixed random stream with random gaps
  task automatic test_random_stream(input int count);
    tri_item_t it;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3, 0))
        0: for (int i = 0; i < 12; i++) it.c[i] = any_coord();
        1: it = sane_triangle(32'h00100000);
        2: it = sane_triangle(32'h0000FFFF);
        default: it = sane_triangle(32'h3FFFFFFF);
      endcase
      send_item(it);
    end
  endtask

  // receiver stalls long while sender pushes back to back
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int n = 0; n < 80; n++) send_item(sane_triangle(32'h00100000), 1'b1);
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    hold_off    = 1'b0;
    timed_out   = 1'b0;
    rst_n = 1'b0;
    in_item.valid = 1'b0;
    in_item.point_x  = '0; in_item.point_y  = '0; in_item.point_z  = '0;
    in_item.vert_a_x = '0; in_item.vert_a_y = '0; in_item.vert_a_z = '0;
    in_item.vert_b_x = '0; in_item.vert_b_y = '0; in_item.vert_b_z = '0;
    in_item.vert_c_x = '0; in_item.vert_c_y = '0; in_item.vert_c_z = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_triangle();
    test_degenerate();
    test_saturation();
    test_extremes();
    test_random_stream(150);
    test_backpressure();
    test_random_stream(170);
    in_item.valid <= 1'b0;

    // drain, then a margin for the pipeline latency
    while (expected_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("triangle_barycentric_coords_top: match");
    else
      $display("triangle_barycentric_coords_top: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
